// File: sv/vllc_pkg.sv
// ----------------------------------------------------------------------------
// vllc_pkg
// Shared constants and types of the vector load line coalescer.
// ----------------------------------------------------------------------------
`default_nettype none
package vllc_pkg;

  localparam int unsigned MaxElementsDef = 1024;
  localparam int unsigned QueueDepthDef  = 64;

  localparam int unsigned InDataW  = 216;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned CmdW     = 2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_ISSUE = 2'd2;

  localparam logic [1:0] MODE_UNIT    = 2'd0;
  localparam logic [1:0] MODE_INDEXED = 2'd1;
  localparam logic [1:0] MODE_STRIDED = 2'd2;
  localparam logic [1:0] MODE_ORDERED = 2'd3;

  localparam logic REG_MEM_LINE = 1'b0;
  localparam logic REG_REG_LINE = 1'b1;

  // Control of one access to the index queue memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } queue_ctl_t;

endpackage
`default_nettype wire

// File: sv/vector_load_line_coalescer.sv
// ----------------------------------------------------------------------------
// vector_load_line_coalescer
// Groups the elements of a vector load into line requests.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries requests; tuser holds the command (start,
// push index, issue). A start sets up a load, pushes fill the index queue,
// and each granted issue emits one master-stream result per element of the
// next line group, tlast marking the last element of the group.
// Configuration writes set the memory and register-file line sizes.
// An issue sets up the group walk, in indexed mode through the ST_FIRST
// state for the first queue memory read, and then registers the elements
// of the group in turn; the next request is taken after the last element
// of the group sits in the output register.
// The output register decouples the sides: a stalled receiver holds the
// group walk, and no request is taken during the walk. Once the last
// element of a group is registered, requests are taken even while it waits.
// Reset returns the block to idle with an empty index queue and both line
// sizes at 64 bytes. The queue memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_load_line_coalescer #(
  parameter int unsigned MAX_ELEMENTS      = vllc_pkg::MaxElementsDef,
  parameter int unsigned INDEX_QUEUE_DEPTH = vllc_pkg::QueueDepthDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // base[63:0], vector_length[74:64], elem_size_log2[76:75],
  // access_mode[78:77], stride_bytes[142:79], memory_target[143],
  // index_size_log2[145:144], index_value[209:146], grant[210]
  input  wire [vllc_pkg::InDataW-1:0]   s_axis_tdata,
  // command[1:0]
  input  wire [vllc_pkg::CmdW-1:0]      s_axis_tuser,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // element_index[9:0], line_address[73:10], byte_offset[79:74],
  // target_out[80], last_element[81]
  output logic [vllc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire                           cfg_we_i,
  input  wire                           cfg_idx_i,
  input  wire [2:0]                     cfg_data_i
);
  import vllc_pkg::*;

  localparam int unsigned QAW = (INDEX_QUEUE_DEPTH > 1) ? $clog2(INDEX_QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(INDEX_QUEUE_DEPTH + 1);
  localparam logic [QCW:0] DepthC = (QCW+1)'(INDEX_QUEUE_DEPTH);
  localparam logic [QAW-1:0] LastSlot = QAW'(INDEX_QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_FIRST, ST_STEP} state_e;

  // Input fields.
  logic [63:0] in_base, in_stride, in_index;
  logic [10:0] in_len;
  logic [1:0]  in_esz, in_mode, in_isz, in_cmd;
  logic        in_tgt, in_grant;
  assign in_base   = s_axis_tdata[63:0];
  assign in_len    = s_axis_tdata[74:64];
  assign in_esz    = s_axis_tdata[76:75];
  assign in_mode   = s_axis_tdata[78:77];
  assign in_stride = s_axis_tdata[142:79];
  assign in_tgt    = s_axis_tdata[143];
  assign in_isz    = s_axis_tdata[145:144];
  assign in_index  = s_axis_tdata[209:146];
  assign in_grant  = s_axis_tdata[210];
  assign in_cmd    = s_axis_tuser;

  state_e      state_q;
  logic [2:0]  mem_lg_q, reg_lg_q;
  logic        busy_q, tgt_q;
  logic [1:0]  mode_q, esz_q, isz_q;
  logic [63:0] base_q, stride_q, cur_addr_q, pend_addr_q, line_q;
  logic [10:0] total_q, next_q, elem_q;
  logic [6:0]  cap_q, k_q;
  logic [5:0]  mask_q;
  logic [QAW-1:0] head_q, rp_q;
  logic [QCW-1:0] count_q;

  logic        out_valid_q, out_last_q;
  logic [OutDataW-1:0] out_data_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign s_axis_tready = (state_q == ST_IDLE);

  logic in_fire, can_emit;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign can_emit = !out_valid_q || m_axis_tready;

  // Line geometry of the active target.
  logic [2:0] lg_raw, lg;
  logic [6:0] mask_w;
  logic [6:0] cap_line, cap_q1, cap_w;
  logic [10:0] remain;
  assign lg_raw = tgt_q ? reg_lg_q : mem_lg_q;
  assign lg     = (lg_raw < 3'd3) ? 3'd3 : ((lg_raw > 3'd6) ? 3'd6 : lg_raw);
  assign mask_w = (7'd1 << lg) - 7'd1;
  assign cap_line = 7'd1 << (lg - {1'b0, esz_q});
  assign remain = total_q - next_q;
  always_comb begin
    cap_q1 = cap_line;
    if (mode_q == MODE_INDEXED && {{(8 > QCW ? 8 - QCW : 0){1'b0}}, count_q} < 8'(cap_line)) begin
      cap_q1 = 7'(count_q);
    end
    cap_w = (11'(cap_q1) > remain) ? remain[6:0] : cap_q1;
  end

  // Queue memory.
  queue_ctl_t  q_ctl;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [63:0] q_wdata, q_rdata;
  logic [QCW:0] tail_sum;
  logic [QAW-1:0] rp_inc;
  assign tail_sum = (QCW+1)'(head_q) + (QCW+1)'(count_q);
  assign q_waddr  = (tail_sum >= DepthC) ? QAW'(tail_sum - DepthC) : QAW'(tail_sum);
  always_comb begin
    q_wdata = in_index;
    case (isz_q)
      2'd0:    q_wdata = {56'd0, in_index[7:0]};
      2'd1:    q_wdata = {48'd0, in_index[15:0]};
      2'd2:    q_wdata = {32'd0, in_index[31:0]};
      default: q_wdata = in_index;
    endcase
  end
  assign rp_inc = (q_raddr == LastSlot) ? '0 : q_raddr + QAW'(1);

  logic issue_ok;
  assign issue_ok = busy_q && in_grant && !(mode_q == MODE_INDEXED && count_q == '0);

  // Next element address and grouping decision.
  logic [63:0] inc, step_addr, pend_first;
  logic        have_next, same_line;
  assign inc        = (mode_q == MODE_STRIDED) ? stride_q : (64'd1 << esz_q);
  assign step_addr  = (mode_q == MODE_INDEXED) ? base_q + q_rdata : pend_addr_q + inc;
  assign pend_first = base_q + q_rdata;
  assign have_next  = (k_q + 7'd1) < cap_q;
  assign same_line  = have_next && (step_addr[63:6] == line_q[63:6]) &&
                      ((step_addr[5:0] & ~mask_q) == line_q[5:0]);

  // An indexed-mode issue reads the queue head; the walk then reads one entry ahead.
  always_comb begin
    q_ctl.wr_en = in_fire && in_cmd == CMD_PUSH && busy_q && (32'(count_q) < INDEX_QUEUE_DEPTH);
    q_ctl.rd_en = 1'b0;
    q_raddr     = (state_q == ST_IDLE) ? head_q : rp_q;
    case (state_q)
      ST_IDLE:  q_ctl.rd_en = in_fire && in_cmd == CMD_ISSUE && issue_ok &&
                              mode_q == MODE_INDEXED;
      ST_FIRST: q_ctl.rd_en = 1'b1;
      ST_STEP:  q_ctl.rd_en = can_emit && same_line && mode_q == MODE_INDEXED;
      default:  q_ctl.rd_en = 1'b0;
    endcase
  end

  vllc_index_ram #(.Depth(INDEX_QUEUE_DEPTH), .AddrW(QAW)) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (q_ctl),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  logic [10:0] len_sat;
  assign len_sat = (32'(in_len) > MAX_ELEMENTS) ? 11'(MAX_ELEMENTS) : in_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mem_lg_q    <= 3'd6;
      reg_lg_q    <= 3'd6;
      busy_q      <= 1'b0;
      mode_q      <= MODE_UNIT;
      tgt_q       <= 1'b0;
      esz_q       <= '0;
      isz_q       <= '0;
      total_q     <= '0;
      next_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MEM_LINE) mem_lg_q <= cfg_data_i;
        else                           reg_lg_q <= cfg_data_i;
      end
      // Outside the walk the output register only drains.
      if (state_q != ST_STEP && m_axis_tready) out_valid_q <= 1'b0;
      if (q_ctl.rd_en) rp_q <= rp_inc;
      if (q_ctl.wr_en) count_q <= count_q + QCW'(1);
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_cmd)
              CMD_START: begin
                if (!busy_q && in_len != '0 && in_mode != MODE_ORDERED) begin
                  busy_q     <= 1'b1;
                  mode_q     <= in_mode;
                  tgt_q      <= in_tgt;
                  base_q     <= in_base;
                  stride_q   <= in_stride;
                  esz_q      <= in_esz;
                  isz_q      <= in_isz;
                  total_q    <= len_sat;
                  next_q     <= '0;
                  cur_addr_q <= in_base;
                  count_q    <= '0;
                  head_q     <= '0;
                end
              end
              CMD_ISSUE: begin
                if (issue_ok) begin
                  cap_q  <= cap_w;
                  mask_q <= mask_w[5:0];
                  k_q    <= '0;
                  elem_q <= next_q;
                  if (mode_q == MODE_INDEXED) begin
                    state_q <= ST_FIRST;
                  end else begin
                    pend_addr_q <= cur_addr_q;
                    line_q      <= {cur_addr_q[63:6], cur_addr_q[5:0] & ~mask_w[5:0]};
                    state_q     <= ST_STEP;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_FIRST: begin
          pend_addr_q <= pend_first;
          line_q      <= {pend_first[63:6], pend_first[5:0] & ~mask_q};
          state_q     <= ST_STEP;
        end
        ST_STEP: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_last_q  <= !same_line;
            out_data_q  <= {6'd0, (elem_q + 11'd1 == total_q), tgt_q,
                            pend_addr_q[5:0] & mask_q, line_q, elem_q[9:0]};
            if (mode_q == MODE_INDEXED) begin
              head_q <= (head_q == LastSlot) ? '0 : head_q + QAW'(1);
              count_q <= count_q - QCW'(1);
            end
            if (same_line) begin
              pend_addr_q <= step_addr;
              k_q         <= k_q + 7'd1;
              elem_q      <= elem_q + 11'd1;
            end else begin
              next_q     <= elem_q + 11'd1;
              cur_addr_q <= step_addr;
              if (elem_q + 11'd1 >= total_q) busy_q <= 1'b0;
              state_q    <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/vllc_index_ram.sv
// ----------------------------------------------------------------------------
// vllc_index_ram
// Index value memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module vllc_index_ram #(
  parameter int unsigned Depth = vllc_pkg::QueueDepthDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire                      clk_i,
  input  wire vllc_pkg::queue_ctl_t ctl_i,
  input  wire [AddrW-1:0]          waddr_i,
  input  wire [63:0]               wdata_i,
  input  wire [AddrW-1:0]          raddr_i,
  output logic [63:0]              rdata_o
);
  import vllc_pkg::*;

  logic [63:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/vllc_checker.sv
// ----------------------------------------------------------------------------
// vllc_checker
// Port-level checks of the vector load line coalescer.
// ----------------------------------------------------------------------------
`default_nettype none
module vllc_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire [vllc_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire                           m_axis_tlast,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready
);
  import vllc_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // The final element of a vector always closes its line request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[81] |-> m_axis_tlast)
    else $error("final element not last in line");

  // Lines are at least eight bytes, so the line address is aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:10] == 3'd0)
    else $error("line address not aligned");

endmodule

bind vector_load_line_coalescer vllc_checker u_vllc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
`default_nettype wire
